// ----- hdl/kabf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package kabf_pkg;

    typedef struct packed {
        logic signed [26:0] meas_angle;
        logic signed [31:0] meas_rate;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] angle_out;
        logic signed [31:0] bias_out;
    } t_out_word;

    localparam logic [1:0] CFG_Q_ANGLE = 2'd0;
    localparam logic [1:0] CFG_Q_BIAS  = 2'd1;
    localparam logic [1:0] CFG_R_MEAS  = 2'd2;
    localparam logic [1:0] CFG_DT      = 2'd3;

    localparam logic [30:0] RST_Q_ANGLE = 31'd16777;
    localparam logic [30:0] RST_Q_BIAS  = 31'd50332;
    localparam logic [30:0] RST_R_MEAS  = 31'd503316;
    localparam logic [30:0] RST_DT      = 31'd335544;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -66'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- hdl/kabf_mul.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Registered fixed-point multiplier with round half up and saturation.
module kabf_mul #(
    parameter int FRAC_BITS = 24
) (
    input  wire                i_clk,
    input  wire signed [31:0]  i_a,
    input  wire signed [31:0]  i_b,
    output logic signed [31:0] o_p
);
    logic signed [63:0] r_prod;
    logic signed [65:0] w_rnd;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign w_rnd = (66'(r_prod) + (66'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    assign o_p   = kabf_pkg::sat32(w_rnd);
endmodule
`default_nettype wire

// ----- hdl/kabf_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Signed restoring divider, one quotient bit per cycle, truncating toward zero.
module kabf_div #(
    parameter int FRAC_BITS = 24
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_start,
    input  wire signed [31:0]  i_num,
    input  wire signed [33:0]  i_den,
    output logic               o_done,
    output logic signed [31:0] o_quo
);
    localparam int NW = 32 + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] r_dvd;
    logic [NW-1:0] r_quo;
    logic [34:0]   r_rem;
    logic [33:0]   r_den;
    logic          r_neg;
    logic          r_zero;
    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [34:0]   w_sh;
    logic [33:0]   w_an;
    logic [NW:0]   w_q;
    logic signed [65:0] w_sq;

    assign w_an = i_den[33] ? 34'(-i_den) : i_den;
    assign w_sh = {r_rem[33:0], r_dvd[NW-1]};
    assign w_q  = r_neg ? -{1'b0, r_quo} : {1'b0, r_quo};
    assign w_sq = 66'(signed'(w_q));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
                r_rem  <= '0;
                r_quo  <= '0;
                r_den  <= w_an;
                r_zero <= (i_den == '0);
                r_neg  <= i_num[31] ^ i_den[33];
                r_dvd  <= NW'(i_num[31] ? 33'(-33'(i_num)) : 33'(i_num)) << FRAC_BITS;
            end else if (r_busy) begin
                r_dvd <= r_dvd << 1;
                if (w_sh >= {1'b0, r_den}) begin
                    r_rem <= w_sh - {1'b0, r_den};
                    r_quo <= {r_quo[NW-2:0], 1'b1};
                end else begin
                    r_rem <= w_sh;
                    r_quo <= {r_quo[NW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_quo = r_zero ? 32'sd0 : kabf_pkg::sat32(w_sq);
endmodule
`default_nettype wire

// ----- hdl/kalman_angle_bias_filter_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Two-state tilt Kalman filter (angle and gyro bias) in signed fixed point with
// FRAC_BITS fraction bits. One word is taken at a time: a shared registered
// multiplier runs ten products under a sequencer, and a bit-serial divider
// forms each of the two gains in turn. The result word is held in an output
// register, so the next word can be accepted in the cycle after the result is
// loaded, even while that result is still stalled; the last step waits only
// while an earlier result has not been taken.
module kalman_angle_bias_filter_unit #(
    parameter int FRAC_BITS = 24
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  kabf_pkg::t_in_word  i_in_data,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output kabf_pkg::t_out_word o_out_data,
    input  wire                 i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire  [1:0]          i_cfg_index,
    input  wire  [30:0]         i_cfg_data
);
    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_RATE = 5'd1;
    localparam logic [4:0] S_M1   = 5'd2;
    localparam logic [4:0] S_M2   = 5'd3;
    localparam logic [4:0] S_M3   = 5'd4;
    localparam logic [4:0] S_M4   = 5'd5;
    localparam logic [4:0] S_D0   = 5'd6;
    localparam logic [4:0] S_D1   = 5'd7;
    localparam logic [4:0] S_M5   = 5'd8;
    localparam logic [4:0] S_M6   = 5'd9;
    localparam logic [4:0] S_M7   = 5'd10;
    localparam logic [4:0] S_M8   = 5'd11;
    localparam logic [4:0] S_M9   = 5'd12;
    localparam logic [4:0] S_M10  = 5'd13;
    localparam logic [4:0] S_OUT  = 5'd14;

    logic [30:0] r_qa, r_qb, r_rm, r_dt;
    logic signed [31:0] r_ang, r_bias, r_p00, r_p01, r_p10, r_p11;
    logic signed [31:0] r_rate, r_t, r_k0, r_k1, r_y;
    logic signed [26:0] r_meas;
    logic [4:0]  r_st;
    logic        r_ph;
    logic        r_dstart;
    logic        r_ovalid;
    kabf_pkg::t_out_word r_odata;

    logic signed [31:0] w_ma, w_mb, w_mp, w_quo;
    logic signed [33:0] w_s;
    logic               w_ddone;

    kabf_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .i_clk(i_clk), .i_a(w_ma), .i_b(w_mb), .o_p(w_mp)
    );

    assign w_s = 34'(r_p00) + 34'(signed'({1'b0, r_rm}));

    kabf_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_dstart),
        .i_num((r_st == S_D0) ? r_p00 : r_p10), .i_den(w_s),
        .o_done(w_ddone), .o_quo(w_quo)
    );

    always_comb begin
        w_ma = 32'(signed'({1'b0, r_dt}));
        w_mb = r_rate;
        unique case (r_st)
            S_M2:    w_mb = r_p11;
            S_M3:    w_mb = r_t;
            S_M4:    begin
                w_ma = 32'(signed'({1'b0, r_qb}));
                w_mb = 32'(signed'({1'b0, r_dt}));
            end
            S_M5:    begin w_ma = r_k0; w_mb = r_y;   end
            S_M6:    begin w_ma = r_k1; w_mb = r_y;   end
            S_M7:    begin w_ma = r_k0; w_mb = r_p00; end
            S_M8:    begin w_ma = r_k0; w_mb = r_p01; end
            S_M9:    begin w_ma = r_k1; w_mb = r_p00; end
            S_M10:   begin w_ma = r_k1; w_mb = r_p01; end
            default: w_mb = r_rate;
        endcase
    end

    assign o_in_stall  = (r_st != S_IDLE);
    assign o_cfg_ready = (r_st == S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qa <= kabf_pkg::RST_Q_ANGLE;
            r_qb <= kabf_pkg::RST_Q_BIAS;
            r_rm <= kabf_pkg::RST_R_MEAS;
            r_dt <= kabf_pkg::RST_DT;
            r_ang <= '0; r_bias <= '0;
            r_p00 <= '0; r_p01 <= '0; r_p10 <= '0; r_p11 <= '0;
            r_st <= S_IDLE;
            r_ph <= 1'b0;
            r_dstart <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_dstart <= 1'b0;
            if (r_ovalid && !i_out_stall) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    kabf_pkg::CFG_Q_ANGLE: r_qa <= i_cfg_data;
                    kabf_pkg::CFG_Q_BIAS:  r_qb <= i_cfg_data;
                    kabf_pkg::CFG_R_MEAS:  r_rm <= i_cfg_data;
                    kabf_pkg::CFG_DT:      r_dt <= i_cfg_data;
                    default: ;
                endcase
            end
            unique case (r_st)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_meas <= i_in_data.meas_angle;
                        r_rate <= kabf_pkg::sat32(66'(i_in_data.meas_rate) - 66'(r_bias));
                        r_st   <= S_RATE;
                        r_ph   <= 1'b0;
                    end
                end
                S_RATE, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7, S_M8, S_M9,
                S_M10: begin
                    r_ph <= ~r_ph;
                    if (r_ph) begin
                        r_ph <= 1'b0;
                        unique case (r_st)
                            S_RATE: begin
                                r_ang <= kabf_pkg::sat32(66'(r_ang) + 66'(w_mp));
                                r_st <= S_M2;
                            end
                            S_M2: begin
                                r_t <= kabf_pkg::sat32(66'(w_mp) - 66'(r_p01) - 66'(r_p10)
                                    + 66'(signed'({1'b0, r_qa})));
                                r_p01 <= kabf_pkg::sat32(66'(r_p01) - 66'(w_mp));
                                r_p10 <= kabf_pkg::sat32(66'(r_p10) - 66'(w_mp));
                                r_st <= S_M3;
                            end
                            S_M3: begin
                                r_p00 <= kabf_pkg::sat32(66'(r_p00) + 66'(w_mp));
                                r_st <= S_M4;
                            end
                            S_M4: begin
                                r_p11 <= kabf_pkg::sat32(66'(r_p11) + 66'(w_mp));
                                r_y <= kabf_pkg::sat32(66'(r_meas) - 66'(r_ang));
                                r_dstart <= 1'b1;
                                r_st <= S_D0;
                            end
                            S_M5: begin
                                r_ang <= kabf_pkg::sat32(66'(r_ang) + 66'(w_mp));
                                r_st <= S_M6;
                            end
                            S_M6: begin
                                r_bias <= kabf_pkg::sat32(66'(r_bias) + 66'(w_mp));
                                r_st <= S_M7;
                            end
                            S_M7: begin
                                r_t <= kabf_pkg::sat32(66'(r_p00) - 66'(w_mp));
                                r_st <= S_M8;
                            end
                            S_M8: begin
                                r_y <= kabf_pkg::sat32(66'(r_p01) - 66'(w_mp));
                                r_st <= S_M9;
                            end
                            S_M9: begin
                                r_p10 <= kabf_pkg::sat32(66'(r_p10) - 66'(w_mp));
                                r_st <= S_M10;
                            end
                            default: begin
                                r_p11 <= kabf_pkg::sat32(66'(r_p11) - 66'(w_mp));
                                r_p00 <= r_t;
                                r_p01 <= r_y;
                                r_st <= S_OUT;
                            end
                        endcase
                    end
                end
                S_D0: begin
                    if (w_ddone) begin
                        r_k0 <= w_quo;
                        r_dstart <= 1'b1;
                        r_st <= S_D1;
                    end
                end
                S_D1: begin
                    if (w_ddone) begin
                        r_k1 <= w_quo;
                        r_st <= S_M5;
                        r_ph <= 1'b0;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || !i_out_stall) begin
                        r_odata.angle_out <= r_ang;
                        r_odata.bias_out  <= r_bias;
                        r_ovalid <= 1'b1;
                        r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- tb/kalman_angle_bias_filter_unit_tb.sv -----
`timescale 1ns / 1ps
`default_nettype none
module kalman_angle_bias_filter_unit_tb;

    localparam int FRAC = 24;
    localparam int CYCLE_LIMIT = 2000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    kabf_pkg::t_in_word in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    kabf_pkg::t_out_word out_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = kabf_pkg::CFG_Q_ANGLE;
    logic [30:0] cfg_data = '0;

    kalman_angle_bias_filter_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_data(out_data),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Filter state mirrored in the testbench.
    logic [30:0] q_angle, q_bias, r_meas, dt;
    logic signed [31:0] angle_est, bias_est, p00, p01, p10, p11;

    kabf_pkg::t_in_word pending_words[$];
    kabf_pkg::t_out_word filtered_words[$];
    int unsigned mismatches = 0;
    int unsigned words_sent = 0;
    int unsigned words_seen = 0;
    int unsigned cycles = 0;
    bit idle_free = 1'b0;

    function automatic logic signed [31:0] clamp(input logic signed [65:0] v);
        if (v > 66'sd2147483647) return 32'sh7fffffff;
        if (v < -66'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] qmul(input logic signed [32:0] a,
                                                 input logic signed [32:0] b);
        logic signed [65:0] p;
        p = a * b;
        p = p + (66'sd1 <<< (FRAC - 1));
        return clamp(p >>> FRAC);
    endfunction

    function automatic logic signed [31:0] qdiv(input logic signed [33:0] num,
                                                 input logic signed [34:0] den);
        logic signed [65:0] n;
        logic signed [65:0] q;
        if (den == 0) return '0;
        n = num;
        n = n <<< FRAC;
        q = n / 66'(den);
        return clamp(q);
    endfunction

    task automatic filter_step(input kabf_pkg::t_in_word w);
        logic signed [31:0] rate, t, inner, k0, k1, y, c00, c01;
        logic signed [34:0] s;
        logic signed [32:0] dts;
        dts = {2'b00, dt};
        rate = clamp(66'(w.meas_rate) - 66'(bias_est));
        angle_est = clamp(66'(angle_est) + 66'(qmul(dts, rate)));
        t = qmul(dts, p11);
        inner = clamp(66'(t) - 66'(p01) - 66'(p10) + 66'($signed({1'b0, q_angle})));
        p00 = clamp(66'(p00) + 66'(qmul(dts, inner)));
        p01 = clamp(66'(p01) - 66'(t));
        p10 = clamp(66'(p10) - 66'(t));
        p11 = clamp(66'(p11) + 66'(qmul({2'b00, q_bias}, dts)));
        s = 35'(p00) + 35'($signed({1'b0, r_meas}));
        k0 = qdiv(34'(p00), s);
        k1 = qdiv(34'(p10), s);
        y = clamp(66'(w.meas_angle) - 66'(angle_est));
        angle_est = clamp(66'(angle_est) + 66'(qmul(k0, y)));
        bias_est = clamp(66'(bias_est) + 66'(qmul(k1, y)));
        c00 = p00;
        c01 = p01;
        p00 = clamp(66'(p00) - 66'(qmul(k0, c00)));
        p01 = clamp(66'(p01) - 66'(qmul(k0, c01)));
        p10 = clamp(66'(p10) - 66'(qmul(k1, c00)));
        p11 = clamp(66'(p11) - 66'(qmul(k1, c01)));
        filtered_words.push_back(kabf_pkg::t_out_word'{angle_out: angle_est,
                                                        bias_out: bias_est});
    endtask

    // Driver.
    int send_gap = 0;
    always @(posedge i_clk) begin
        kabf_pkg::t_in_word w;
        if (i_rst_n) begin
            if (in_valid && !in_stall) begin
                filter_step(in_data);
                words_sent++;
            end
            if (!in_valid || !in_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    w = pending_words.pop_front();
                    in_data <= w;
                    in_valid <= 1'b1;
                    if (!idle_free && $urandom_range(0, 7) == 0) begin
                        send_gap = $urandom_range(1, 15);
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor.
    int stall_left = 0;
    always @(posedge i_clk) begin
        kabf_pkg::t_out_word want;
        cycles++;
        if (i_rst_n) begin
            if (out_valid && !out_stall) begin
                words_seen++;
                if (filtered_words.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("Unexpected result word: angle %0d bias %0d",
                                 out_data.angle_out, out_data.bias_out);
                    end
                end else begin
                    want = filtered_words.pop_front();
                    if (out_data.angle_out !== want.angle_out
                            || out_data.bias_out !== want.bias_out) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("Mismatch: angle %0d/%0d bias %0d/%0d",
                                     want.angle_out, out_data.angle_out,
                                     want.bias_out, out_data.bias_out);
                        end
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else if (!idle_free && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(0, 14);
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles.", cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [30:0] val);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            kabf_pkg::CFG_Q_ANGLE: q_angle = val;
            kabf_pkg::CFG_Q_BIAS: q_bias = val;
            kabf_pkg::CFG_R_MEAS: r_meas = val;
            default: dt = val;
        endcase
    endtask

    task automatic drain;
        while (pending_words.size() > 0 || filtered_words.size() > 0 || in_valid) begin
            @(posedge i_clk);
        end
        repeat (300) @(posedge i_clk);
    endtask

    task automatic add_random(input int n, input bit wild);
        kabf_pkg::t_in_word w;
        for (int k = 0; k < n; k++) begin
            if (wild && $urandom_range(0, 3) == 0) begin
                w.meas_angle = 27'($urandom);
                w.meas_rate = $urandom;
            end else begin
                w.meas_angle = 27'($signed($urandom_range(0, 2 * 52707179)) - 52707179);
                w.meas_rate = $signed($urandom_range(0, 2 * 16777216)) - 16777216;
            end
            pending_words.push_back(w);
        end
    endtask

    initial begin
        kabf_pkg::t_in_word w;
        q_angle = kabf_pkg::RST_Q_ANGLE;
        q_bias = kabf_pkg::RST_Q_BIAS;
        r_meas = kabf_pkg::RST_R_MEAS;
        dt = kabf_pkg::RST_DT;
        angle_est = '0;
        bias_est = '0;
        p00 = '0;
        p01 = '0;
        p10 = '0;
        p11 = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        w = '{meas_angle: 27'sd52707179, meas_rate: 32'sh7fffffff};
        pending_words.push_back(w);
        w = '{meas_angle: -27'sd52707179, meas_rate: 32'sh80000000};
        pending_words.push_back(w);
        w = '{meas_angle: 27'sh3ffffff, meas_rate: 32'sd0};
        pending_words.push_back(w);
        w = '{meas_angle: 27'sh4000000, meas_rate: -32'sd1};
        pending_words.push_back(w);
        w = '{meas_angle: 27'sd0, meas_rate: 32'sd0};
        pending_words.push_back(w);
        add_random(10, 1'b0);
        drain();

        // Zero noise, zero step: the innovation variance can become zero.
        write_reg(kabf_pkg::CFG_R_MEAS, 31'd0);
        write_reg(kabf_pkg::CFG_DT, 31'd0);
        write_reg(kabf_pkg::CFG_Q_ANGLE, 31'd0);
        add_random(8, 1'b0);
        drain();

        write_reg(kabf_pkg::CFG_Q_ANGLE, 31'h7fffffff);
        write_reg(kabf_pkg::CFG_Q_BIAS, 31'h7fffffff);
        write_reg(kabf_pkg::CFG_R_MEAS, 31'h7fffffff);
        write_reg(kabf_pkg::CFG_DT, 31'h7fffffff);
        add_random(100, 1'b1);
        drain();

        write_reg(kabf_pkg::CFG_Q_ANGLE, 31'd1);
        write_reg(kabf_pkg::CFG_Q_BIAS, 31'd0);
        write_reg(kabf_pkg::CFG_R_MEAS, 31'd1);
        write_reg(kabf_pkg::CFG_DT, 31'd1);
        add_random(100, 1'b1);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            write_reg(kabf_pkg::CFG_Q_ANGLE, 31'($urandom_range(0, 1 << 20)));
            write_reg(kabf_pkg::CFG_Q_BIAS, 31'($urandom_range(0, 1 << 20)));
            write_reg(kabf_pkg::CFG_R_MEAS, 31'($urandom_range(1, 1 << 24)));
            write_reg(kabf_pkg::CFG_DT, 31'($urandom_range(1, 1 << 23)));
            add_random(200, ph > 3);
            drain();
        end

        write_reg(kabf_pkg::CFG_Q_ANGLE, kabf_pkg::RST_Q_ANGLE);
        write_reg(kabf_pkg::CFG_Q_BIAS, kabf_pkg::RST_Q_BIAS);
        write_reg(kabf_pkg::CFG_R_MEAS, kabf_pkg::RST_R_MEAS);
        write_reg(kabf_pkg::CFG_DT, kabf_pkg::RST_DT);
        idle_free = 1'b1;
        add_random(300, 1'b0);
        drain();

        $display("Sent %0d input words and checked %0d result words across",
                 words_sent, words_seen);
        $display("default, extreme and random register settings.");
        if (mismatches == 0 && filtered_words.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches.", mismatches);
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
